// File: rtl/aik_pkg.sv
// Shared types, constants and the arctangent table of the arm solver.
`timescale 1ns / 1ps
package aik_pkg;

   localparam int unsigned CORDIC_STAGES_DEF = 16;
   localparam int unsigned CSR_IDX_W = 4;
   localparam int unsigned CFG_W = 20;
   localparam int unsigned FRAC_BITS = 30;
   localparam int unsigned XY_W = 45;
   localparam int unsigned ANG_W = 34;
   localparam int unsigned NORM_MSB = 40;
   localparam logic [ANG_W-1:0] HALF_PI_Q30 = 34'd1686629713;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_HEIGHT = 0,
      CSR_UPPER_LINK  = 1,
      CSR_FORE_LINK   = 2,
      CSR_TOOL_OFFSET = 3
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } req_type;

   typedef struct packed {
      logic               result_valid;
      logic               radicand_clamped;
      logic signed [15:0] base_angle;
      logic signed [15:0] shoulder_angle;
      logic signed [15:0] elbow_angle;
      logic signed [15:0] wrist_angle;
      logic signed [15:0] roll_angle;
   } rsp_type;

   // atan(2^-i) in Q3.30
   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:  val = 30'h3243F6A8;
         5'd1:  val = 30'h1DAC6705;
         5'd2:  val = 30'h0FADBAFC;
         5'd3:  val = 30'h07F56EA6;
         5'd4:  val = 30'h03FEAB76;
         5'd5:  val = 30'h01FFD55B;
         5'd6:  val = 30'h00FFFAAA;
         5'd7:  val = 30'h007FFF55;
         5'd8:  val = 30'h003FFFEA;
         5'd9:  val = 30'h001FFFFD;
         5'd10: val = 30'h000FFFFF;
         5'd11: val = 30'h0007FFFF;
         5'd12: val = 30'h0003FFFF;
         5'd13: val = 30'h0001FFFF;
         5'd14: val = 30'h0000FFFF;
         5'd15: val = 30'h00007FFF;
         5'd16: val = 30'h00003FFF;
         5'd17: val = 30'h00001FFF;
         5'd18: val = 30'h00000FFF;
         5'd19: val = 30'h000007FF;
         5'd20: val = 30'h000003FF;
         5'd21: val = 30'h000001FF;
         5'd22: val = 30'h000000FF;
         5'd23: val = 30'h0000007F;
         5'd24: val = 30'h0000003F;
         5'd25: val = 30'h0000001F;
         5'd26: val = 30'h0000000F;
         5'd27: val = 30'h00000008;
         5'd28: val = 30'h00000004;
         5'd29: val = 30'h00000002;
         5'd30: val = 30'h00000001;
         default: val = 30'h00000000;
      endcase
      return val;
   endfunction

   // round Q3.30 to Q3.12: add half an LSB, floor
   function automatic logic [15:0] to_q12(input logic signed [35:0] z);
      logic signed [35:0] t;
      t = z + 36'sd131072;
      return t[33:18];
   endfunction

endpackage

// File: rtl/aik_delay.sv
// Enabled shift line that aligns a word with the rest of the pipeline.
`timescale 1ns / 1ps
module aik_delay #(
   parameter int unsigned W = 1,
   parameter int unsigned N = 1
) (
   input  logic         clock,
   input  logic         advance,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] line_ff [N];

   always_ff @(posedge clock) begin
      if (advance) begin
         line_ff[0] <= din;
         for (int i = 1; i < N; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[N-1];

endmodule

// File: rtl/aik_isqrt.sv
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps
module aik_isqrt #(
   parameter int unsigned N = 64
) (
   input  logic           clock,
   input  logic           advance,
   input  logic [N-1:0]   rad,
   output logic [N/2-1:0] root
);

   localparam int unsigned STEPS = N / 2;
   localparam logic [N-1:0] ONE = 1;

   logic [N-1:0] v_ff   [STEPS];
   logic [N-1:0] res_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic [N-1:0] BIT = ONE << (N - 2 - 2 * i);
      logic [N-1:0] v_prev;
      logic [N-1:0] res_prev;
      logic [N:0]   trial;

      if (i == 0) begin : g_first
         assign v_prev   = rad;
         assign res_prev = '0;
      end else begin : g_next
         assign v_prev   = v_ff[i-1];
         assign res_prev = res_ff[i-1];
      end

      assign trial = {1'b0, res_prev} + {1'b0, BIT};

      always_ff @(posedge clock) begin
         if (advance) begin
            if ({1'b0, v_prev} >= trial) begin
               v_ff[i]   <= v_prev - trial[N-1:0];
               res_ff[i] <= (res_prev >> 1) + BIT;
            end else begin
               v_ff[i]   <= v_prev;
               res_ff[i] <= res_prev >> 1;
            end
         end
      end
   end

   assign root = res_ff[STEPS-1][N/2-1:0];

endmodule

// File: rtl/aik_fracdiv.sv
// Pipelined restoring division giving floor(num * 2^FRAC / den), num <= den.
`timescale 1ns / 1ps
module aik_fracdiv #(
   parameter int unsigned W    = 41,
   parameter int unsigned FRAC = 30
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [W-1:0]  num,
   input  logic [W-1:0]  den,
   output logic [FRAC:0] quot
);

   logic [W-1:0]  rem_ff [FRAC+1];
   logic [FRAC:0] q_ff   [FRAC+1];

   // integer bit first
   always_ff @(posedge clock) begin
      if (advance) begin
         if (num >= den) begin
            rem_ff[0] <= num - den;
            q_ff[0]   <= {{FRAC{1'b0}}, 1'b1};
         end else begin
            rem_ff[0] <= num;
            q_ff[0]   <= '0;
         end
      end
   end

   for (genvar k = 1; k <= FRAC; k++) begin : g_step
      logic [W:0] shifted;
      logic [W:0] diff;

      assign shifted = {rem_ff[k-1], 1'b0};
      assign diff    = shifted - {1'b0, den};

      always_ff @(posedge clock) begin
         if (advance) begin
            if (shifted >= {1'b0, den}) begin
               rem_ff[k] <= diff[W-1:0];
               q_ff[k]   <= {q_ff[k-1][FRAC-1:0], 1'b1};
            end else begin
               rem_ff[k] <= shifted[W-1:0];
               q_ff[k]   <= {q_ff[k-1][FRAC-1:0], 1'b0};
            end
         end
      end
   end

   assign quot = q_ff[FRAC];

endmodule

// File: rtl/aik_cordic.sv
// Pipelined vectoring CORDIC: normalize, fold into the right half plane, rotate.
`timescale 1ns / 1ps
module aik_cordic #(
   parameter int unsigned IN_W   = 32,
   parameter int unsigned STAGES = aik_pkg::CORDIC_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  advance,
   input  logic signed [IN_W-1:0] y_in,
   input  logic signed [IN_W-1:0] x_in,
   output logic signed [aik_pkg::ANG_W-1:0] angle
);

   localparam int unsigned PW = $clog2(IN_W);
   localparam int unsigned XW = aik_pkg::XY_W;
   localparam int unsigned ZW = aik_pkg::ANG_W;
   localparam logic [5:0] NM = 6'(aik_pkg::NORM_MSB);

   // magnitude stage
   logic [IN_W-1:0]        ax, ay;
   logic signed [IN_W-1:0] xa_ff, ya_ff;
   logic [IN_W-1:0]        m_ff;

   assign ax = x_in[IN_W-1] ? -x_in : x_in;
   assign ay = y_in[IN_W-1] ? -y_in : y_in;

   always_ff @(posedge clock) begin
      if (advance) begin
         xa_ff <= x_in;
         ya_ff <= y_in;
         m_ff  <= (ax > ay) ? ax : ay;
      end
   end

   // leading one search
   logic [PW-1:0]          pos;
   logic signed [IN_W-1:0] xb_ff, yb_ff;
   logic [PW-1:0]          pos_ff;
   logic                   zb_ff;

   always_comb begin
      pos = '0;
      for (int b = 0; b < IN_W; b++) begin
         if (m_ff[b]) pos = PW'(b);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xb_ff  <= xa_ff;
         yb_ff  <= ya_ff;
         pos_ff <= pos;
         zb_ff  <= (m_ff == '0);
      end
   end

   // shift into place, fold the left half plane by a quarter turn
   logic signed [XW-1:0] xn, yn;
   logic [5:0]           shl;
   logic signed [XW-1:0] x_ff [STAGES+1];
   logic signed [XW-1:0] y_ff [STAGES+1];
   logic signed [ZW-1:0] z_ff [STAGES+1];
   logic                 zf_ff [STAGES+1];

   assign shl = NM - 6'(pos_ff);
   assign xn  = XW'(xb_ff) <<< shl;
   assign yn  = XW'(yb_ff) <<< shl;

   always_ff @(posedge clock) begin
      if (advance) begin
         zf_ff[0] <= zb_ff;
         if (xn < 0) begin
            if (yn >= 0) begin
               x_ff[0] <= yn;
               y_ff[0] <= -xn;
               z_ff[0] <= $signed(aik_pkg::HALF_PI_Q30);
            end else begin
               x_ff[0] <= -yn;
               y_ff[0] <= xn;
               z_ff[0] <= -$signed(aik_pkg::HALF_PI_Q30);
            end
         end else begin
            x_ff[0] <= xn;
            y_ff[0] <= yn;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_rot
      localparam logic signed [ZW-1:0] ATAN_K = $signed(ZW'(aik_pkg::atan_q30(5'(k))));
      logic signed [XW-1:0] xs, ys;

      assign xs = x_ff[k] >>> k;
      assign ys = y_ff[k] >>> k;

      always_ff @(posedge clock) begin
         if (advance) begin
            zf_ff[k+1] <= zf_ff[k];
            if (y_ff[k] >= 0) begin
               x_ff[k+1] <= x_ff[k] + ys;
               y_ff[k+1] <= y_ff[k] - xs;
               z_ff[k+1] <= z_ff[k] + ATAN_K;
            end else begin
               x_ff[k+1] <= x_ff[k] - ys;
               y_ff[k+1] <= y_ff[k] + xs;
               z_ff[k+1] <= z_ff[k] - ATAN_K;
            end
         end
      end
   end

   // zero vector gives zero angle
   assign angle = zf_ff[STAGES] ? '0 : z_ff[STAGES];

endmodule

// File: rtl/arm_inverse_kinematics.sv
// Top level of the five-joint arm solver: configuration, datapath and flow control.
`timescale 1ns / 1ps
// One target enters per cycle unless a finished word is stalled at the output. The
// pipeline depth is set by the dependent chain elbow cosine division (31 stages),
// sine square root (31 stages), radicand square root (22 stages) and the shoulder
// CORDIC (3 + CORDIC_STAGES stages). The whole pipeline holds while a finished word
// waits at the output and rsp_ready is low. The user must write link lengths through
// the csr port only while no target is in flight; the block does not enforce it.
module arm_inverse_kinematics #(
   parameter int unsigned CORDIC_STAGES = aik_pkg::CORDIC_STAGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  aik_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output aik_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [aik_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [aik_pkg::CFG_W-1:0]        csr_data
);

   localparam int unsigned ST  = CORDIC_STAGES;
   localparam int unsigned LAT = 103 + ST;
   localparam int unsigned ZW  = aik_pkg::ANG_W;

   logic advance;
   logic [LAT:0] v_ff;

   assign advance   = !v_ff[LAT] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = v_ff[LAT];
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[LAT-1:0], req_valid};
      end
   end

   // configuration registers
   logic [19:0] base_height_ff, upper_link_ff, fore_link_ff, tool_offset_ff;
   logic [39:0] ul_sq, fl_sq;
   logic [40:0] t_ff, den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_height_ff <= '0;
         upper_link_ff  <= '0;
         fore_link_ff   <= '0;
         tool_offset_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            aik_pkg::CSR_BASE_HEIGHT: base_height_ff <= csr_data;
            aik_pkg::CSR_UPPER_LINK:  upper_link_ff  <= csr_data;
            aik_pkg::CSR_FORE_LINK:   fore_link_ff   <= csr_data;
            aik_pkg::CSR_TOOL_OFFSET: tool_offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign ul_sq = upper_link_ff * upper_link_ff;
   assign fl_sq = fore_link_ff * fore_link_ff;

   always_ff @(posedge clock) begin
      t_ff   <= {1'b0, ul_sq} + {1'b0, fl_sq};
      den_ff <= {fl_sq, 1'b0};
   end

   // level 0: input word
   aik_pkg::req_type in_ff;

   always_ff @(posedge clock) begin
      if (advance) in_ff <= req_data;
   end

   // level 1: magnitudes, quaternion products
   logic [31:0] tx, ty, ux_in, uy_in;
   logic [33:0] zp;
   logic [32:0] uzp_in;
   logic [31:0] ux_ff, uy_ff;
   logic [32:0] uzp_ff;
   logic signed [31:0] pyz_ff, pwx_ff, sw_ff, sz_ff, sx_ff, sy_ff;

   assign tx     = in_ff.target_x;
   assign ty     = in_ff.target_y;
   assign ux_in  = tx[31] ? -tx : tx;
   assign uy_in  = ty[31] ? -ty : ty;
   assign zp     = {{2{in_ff.target_z[31]}}, in_ff.target_z} - {14'd0, base_height_ff}
                   + {14'd0, tool_offset_ff};
   assign uzp_in = zp[33] ? 33'(-zp) : zp[32:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         ux_ff  <= ux_in;
         uy_ff  <= uy_in;
         uzp_ff <= uzp_in;
         pyz_ff <= in_ff.quat_y * in_ff.quat_z;
         pwx_ff <= in_ff.quat_w * in_ff.quat_x;
         sw_ff  <= in_ff.quat_w * in_ff.quat_w;
         sz_ff  <= in_ff.quat_z * in_ff.quat_z;
         sx_ff  <= in_ff.quat_x * in_ff.quat_x;
         sy_ff  <= in_ff.quat_y * in_ff.quat_y;
      end
   end

   // level 2: squares, roll vector
   logic [65:0] sqz_full;
   logic [63:0] sqx_ff, sqy_ff, sqz_ff;
   logic signed [33:0] roll_y_ff, roll_x_ff;

   assign sqz_full = uzp_ff * uzp_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff    <= ux_ff * ux_ff;
         sqy_ff    <= uy_ff * uy_ff;
         sqz_ff    <= sqz_full[63:0];
         roll_y_ff <= (34'(pyz_ff) + 34'(pwx_ff)) <<< 1;
         roll_x_ff <= 34'(sw_ff) + 34'(sz_ff) - 34'(sx_ff) - 34'(sy_ff);
      end
   end

   // level 3: sums (S wraps at 64 bits)
   logic [63:0] s_ff, rxy_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff   <= sqx_ff + sqy_ff + sqz_ff;
         rxy_ff <= sqx_ff + sqy_ff;
      end
   end

   // level 4: |S - T|
   logic        neg4_ff;
   logic [63:0] nm_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         neg4_ff <= s_ff < {23'd0, t_ff};
         nm_ff   <= (s_ff < {23'd0, t_ff}) ? {23'd0, t_ff} - s_ff : s_ff - {23'd0, t_ff};
      end
   end

   // level 5: reach check
   logic        bad5_ff, neg5_ff;
   logic [40:0] num5_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         bad5_ff <= (den_ff == '0) || (nm_ff > {23'd0, den_ff});
         neg5_ff <= neg4_ff;
         num5_ff <= nm_ff[40:0];
      end
   end

   // elbow cosine magnitude, level 36
   logic [30:0] cm36;
   logic        neg36;

   aik_fracdiv #(.W(41), .FRAC(aik_pkg::FRAC_BITS)) u_cos_div (
      .clock(clock), .advance(advance), .num(num5_ff), .den(den_ff), .quot(cm36)
   );

   aik_delay #(.W(1), .N(31)) u_neg_dly (
      .clock(clock), .advance(advance), .din(neg5_ff), .dout(neg36)
   );

   // radial term, level 35 -> 36
   logic [31:0] r_raw35;
   logic        xnz35;
   logic [31:0] r36_ff;

   aik_isqrt #(.N(64)) u_r_sqrt (
      .clock(clock), .advance(advance), .rad(rxy_ff), .root(r_raw35)
   );

   aik_delay #(.W(1), .N(35)) u_xnz_dly (
      .clock(clock), .advance(advance), .din(in_ff.target_x != '0), .dout(xnz35)
   );

   always_ff @(posedge clock) begin
      if (advance) r36_ff <= xnz35 ? r_raw35 : '0;
   end

   // level 37: signed cosine and its square; level 38: sine radicand
   logic [31:0] cm_ext;
   logic [61:0] cmsq_full;
   logic signed [31:0] c37_ff;
   logic [61:0] cmsq37_ff, srad38_ff;

   assign cm_ext    = {1'b0, cm36};
   assign cmsq_full = cm36 * cm36;

   always_ff @(posedge clock) begin
      if (advance) begin
         c37_ff    <= neg36 ? -cm_ext : cm_ext;
         cmsq37_ff <= cmsq_full;
         srad38_ff <= (62'd1 << 60) - cmsq37_ff;
      end
   end

   // sine, level 69
   logic [30:0] s69;
   logic signed [31:0] c69;

   aik_isqrt #(.N(62)) u_sin_sqrt (
      .clock(clock), .advance(advance), .rad(srad38_ff), .root(s69)
   );

   aik_delay #(.W(32), .N(32)) u_c_dly (
      .clock(clock), .advance(advance), .din(c37_ff), .dout(c69)
   );

   // elbow angle, level 72 + ST
   logic signed [ZW-1:0] elbow_z;

   aik_cordic #(.IN_W(32), .STAGES(ST)) u_elbow (
      .clock(clock), .advance(advance), .y_in($signed({1'b0, s69})), .x_in(c69),
      .angle(elbow_z)
   );

   // level 70: d4*sin and d4*cos truncated toward zero
   logic [31:0] cmag69;
   logic [50:0] dc_prod, ds_prod;
   logic [19:0] b70_ff;
   logic signed [20:0] mc70_ff;

   assign cmag69  = c69[31] ? -c69 : c69;
   assign dc_prod = fore_link_ff * cmag69[30:0];
   assign ds_prod = fore_link_ff * s69;

   always_ff @(posedge clock) begin
      if (advance) begin
         b70_ff  <= ds_prod[49:30];
         mc70_ff <= c69[31] ? -$signed(dc_prod[50:30]) : $signed(dc_prod[50:30]);
      end
   end

   // level 71: A = d3 + d4 cos
   logic signed [21:0] a71_ff;
   logic [19:0] b71_ff;
   logic [31:0] r71;

   always_ff @(posedge clock) begin
      if (advance) begin
         a71_ff <= $signed({2'b00, upper_link_ff}) + 22'(mc70_ff);
         b71_ff <= b70_ff;
      end
   end

   aik_delay #(.W(32), .N(35)) u_r71_dly (
      .clock(clock), .advance(advance), .din(r36_ff), .dout(r71)
   );

   // levels 72..74: radicand and clamp
   logic [21:0] amag71;
   logic [41:0] asq72_ff;
   logic [39:0] bsq72_ff;
   logic [63:0] rsq72_ff, rsq73_ff;
   logic [42:0] p73_ff;
   logic        clamp74_ff;
   logic [43:0] rad74_ff;

   assign amag71 = a71_ff[21] ? -a71_ff : a71_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         asq72_ff   <= amag71[20:0] * amag71[20:0];
         bsq72_ff   <= b71_ff * b71_ff;
         rsq72_ff   <= r71 * r71;
         p73_ff     <= 43'(asq72_ff) + 43'(bsq72_ff);
         rsq73_ff   <= rsq72_ff;
         clamp74_ff <= rsq73_ff > {21'd0, p73_ff};
         rad74_ff   <= (rsq73_ff > {21'd0, p73_ff}) ? '0 : {1'b0, p73_ff - rsq73_ff[42:0]};
      end
   end

   // root of the radicand, level 96
   logic [21:0] sq96;
   logic signed [21:0] a96;
   logic [19:0] b96;
   logic [31:0] r96;

   aik_isqrt #(.N(44)) u_rad_sqrt (
      .clock(clock), .advance(advance), .rad(rad74_ff), .root(sq96)
   );

   aik_delay #(.W(22), .N(25)) u_a_dly (
      .clock(clock), .advance(advance), .din(a71_ff), .dout(a96)
   );

   aik_delay #(.W(20), .N(25)) u_b_dly (
      .clock(clock), .advance(advance), .din(b71_ff), .dout(b96)
   );

   aik_delay #(.W(32), .N(25)) u_r96_dly (
      .clock(clock), .advance(advance), .din(r71), .dout(r96)
   );

   // level 97: half-angle numerator and denominator; level 98: fold sign
   logic [22:0] nsum;
   logic signed [23:0] n97_ff;
   logic signed [33:0] d97_ff;
   logic signed [34:0] ny98_ff, nx98_ff;
   logic bad2_98_ff;

   assign nsum = 23'(b96) + 23'(sq96);

   always_ff @(posedge clock) begin
      if (advance) begin
         n97_ff     <= -$signed({1'b0, nsum});
         d97_ff     <= 34'(a96) + $signed({2'b00, r96});
         bad2_98_ff <= (d97_ff == '0);
         if (d97_ff < 0) begin
            ny98_ff <= -35'(n97_ff);
            nx98_ff <= -35'(d97_ff);
         end else begin
            ny98_ff <= 35'(n97_ff);
            nx98_ff <= 35'(d97_ff);
         end
      end
   end

   // shoulder half angle, level 101 + ST
   logic signed [ZW-1:0] half_z;

   aik_cordic #(.IN_W(35), .STAGES(ST)) u_shoulder (
      .clock(clock), .advance(advance), .y_in(ny98_ff), .x_in(nx98_ff), .angle(half_z)
   );

   // base and roll angles
   logic signed [ZW-1:0] base_z, roll_z;

   aik_cordic #(.IN_W(32), .STAGES(ST)) u_base (
      .clock(clock), .advance(advance), .y_in(in_ff.target_y), .x_in(in_ff.target_x),
      .angle(base_z)
   );

   aik_cordic #(.IN_W(34), .STAGES(ST)) u_roll (
      .clock(clock), .advance(advance), .y_in(roll_y_ff), .x_in(roll_x_ff),
      .angle(roll_z)
   );

   // align everything with the shoulder angle
   logic signed [ZW-1:0] elbow_a, base_a, roll_a;
   logic bad_a, clamp_a, bad2_a;

   aik_delay #(.W(ZW), .N(29)) u_el_dly (
      .clock(clock), .advance(advance), .din(elbow_z), .dout(elbow_a)
   );

   aik_delay #(.W(ZW), .N(98)) u_ba_dly (
      .clock(clock), .advance(advance), .din(base_z), .dout(base_a)
   );

   aik_delay #(.W(ZW), .N(96)) u_ro_dly (
      .clock(clock), .advance(advance), .din(roll_z), .dout(roll_a)
   );

   aik_delay #(.W(1), .N(96 + ST)) u_bad_dly (
      .clock(clock), .advance(advance), .din(bad5_ff), .dout(bad_a)
   );

   aik_delay #(.W(1), .N(27 + ST)) u_cl_dly (
      .clock(clock), .advance(advance), .din(clamp74_ff), .dout(clamp_a)
   );

   aik_delay #(.W(1), .N(3 + ST)) u_bad2_dly (
      .clock(clock), .advance(advance), .din(bad2_98_ff), .dout(bad2_a)
   );

   // level 102 + ST: shoulder and wrist in Q3.30
   logic signed [34:0] shoulder_in;
   logic signed [34:0] sh_ff;
   logic signed [35:0] wr_ff;
   logic signed [ZW-1:0] el_ff, ba_ff, ro_ff;
   logic ok_ff, cl_ff;

   assign shoulder_in = 35'(half_z) <<< 1;

   always_ff @(posedge clock) begin
      if (advance) begin
         sh_ff <= shoulder_in;
         wr_ff <= -(36'(shoulder_in) + 36'(elbow_a));
         el_ff <= elbow_a;
         ba_ff <= base_a;
         ro_ff <= roll_a;
         ok_ff <= !bad_a && !bad2_a;
         cl_ff <= clamp_a;
      end
   end

   // level 103 + ST: output word; an unreachable target gives all zeros
   aik_pkg::rsp_type rsp_in;
   aik_pkg::rsp_type rsp_ff;

   always_comb begin
      rsp_in = '0;
      if (ok_ff) begin
         rsp_in.result_valid     = 1'b1;
         rsp_in.radicand_clamped = cl_ff;
         rsp_in.base_angle       = aik_pkg::to_q12(36'(ba_ff));
         rsp_in.shoulder_angle   = aik_pkg::to_q12(36'(sh_ff));
         rsp_in.elbow_angle      = aik_pkg::to_q12(36'(el_ff));
         rsp_in.wrist_angle      = aik_pkg::to_q12(wr_ff);
         rsp_in.roll_angle       = aik_pkg::to_q12(36'(ro_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // checks
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.result_valid |->
         !rsp_data.radicand_clamped && rsp_data.base_angle == '0 &&
         rsp_data.shoulder_angle == '0 && rsp_data.elbow_angle == '0 &&
         rsp_data.wrist_angle == '0 && rsp_data.roll_angle == '0)
      else $error("unreachable target carries nonzero fields");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output word is stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

endmodule
